// ===== rtl/core/hkim_pkg.sv =====
// Shared constants, types and codes for the hashed key to id map.
package hkim_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BYTES = 8;
  localparam int ID_BITS   = 16;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int HASH_W = 64;
  localparam int LEN_W  = 4;
  localparam int KEY_W  = 64;
  localparam int IDP_W  = 16;
  localparam int STAT_W = 2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd3;

  // source of the reported id
  localparam logic [1:0] SEL_MISS  = 2'd0;
  localparam logic [1:0] SEL_ENTRY = 2'd1;
  localparam logic [1:0] SEL_SLOT  = 2'd2;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [LEN_W-1:0]   len;
    logic [KEY_W-1:0]   key;
    logic [ID_BITS-1:0] id;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic              load;      // capture accepted transaction
    logic              rd;        // read slot at current index
    logic              adv;       // step to next probe
    logic              wr;        // write transaction into current slot
    logic              pend_load; // capture result
    logic [STAT_W-1:0] pend_code;
    logic [1:0]        pend_sel;
    logic              out_load;  // move result to output register
  } cmd_t;

  typedef struct packed {
    logic in_ins_zero; // incoming insert carries zero hash
    logic op_ins;
    logic empty;
    logic match;
    logic last_try;
  } stat_t;

endpackage

// ===== rtl/core/hkim_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module hkim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hkim_ctrl.sv =====
// Probe sequencer state machine for the hashed key to id map.
module hkim_ctrl import hkim_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_ins_zero) begin
            cmd.pend_load = 1'b1;
            cmd.pend_code = ST_ZERO;
            cmd.pend_sel  = SEL_MISS;
            state_next    = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.empty) begin
          cmd.pend_load = 1'b1;
          if (stat.op_ins) begin
            cmd.wr        = 1'b1;
            cmd.pend_code = ST_OK;
            cmd.pend_sel  = SEL_ENTRY;
          end else begin
            cmd.pend_code = ST_MISS;
            cmd.pend_sel  = SEL_MISS;
          end
          state_next = S_DONE;
        end else if (!stat.op_ins && stat.match) begin
          cmd.pend_load = 1'b1;
          cmd.pend_code = ST_OK;
          cmd.pend_sel  = SEL_SLOT;
          state_next    = S_DONE;
        end else if (stat.last_try) begin
          cmd.pend_load = 1'b1;
          cmd.pend_code = stat.op_ins ? ST_FULL : ST_MISS;
          cmd.pend_sel  = SEL_MISS;
          state_next    = S_DONE;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/hkim_dp.sv =====
// Datapath: operand registers, probe index arithmetic, slot table and result registers.
module hkim_dp import hkim_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              cfg_we,
  input  logic [IDP_W-1:0]  cfg_data,
  input  logic              kind,
  input  logic [HASH_W-1:0] key_hash,
  input  logic [LEN_W-1:0]  key_length,
  input  logic [KEY_W-1:0]  key_bytes,
  input  logic [IDP_W-1:0]  entry_id,
  output logic [STAT_W-1:0] status,
  output logic [IDP_W-1:0]  found_id
);

  logic               op_ins;
  logic [HASH_W-1:0]  op_hash;
  logic [LEN_W-1:0]   op_len;
  logic [KEY_W-1:0]   op_key;
  logic [ID_BITS-1:0] op_id;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] sq;   // probe squared, modulo capacity
  logic [IDX_W-1:0] odd;  // 2*probe+1, modulo capacity
  logic [IDX_W-1:0] tries;

  logic [CAPACITY-1:0] slot_vld;
  logic                vld_q;
  slot_t               rd_slot;
  slot_t               wr_slot;

  logic [IDP_W-1:0]  miss_id;
  logic [STAT_W-1:0] pend_code;
  logic [IDP_W-1:0]  pend_id;
  logic [IDP_W-1:0]  pend_id_next;

  logic [KEY_W-1:0] key_diff;
  logic             key_eq;

  assign wr_slot = '{hash: op_hash, len: op_len, key: op_key, id: op_id};

  hkim_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(idx),
    .wdata(wr_slot),
    .re   (cmd.rd),
    .raddr(idx),
    .rdata(rd_slot)
  );

  // compare only the first min(length, KEY_BYTES) bytes
  always_comb begin
    key_diff = rd_slot.key ^ op_key;
    key_eq   = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i < KEY_BYTES && i < int'(op_len) && key_diff[8*i +: 8] != 8'd0) begin
        key_eq = 1'b0;
      end
    end
  end

  assign stat.in_ins_zero = kind && (key_hash == '0);
  assign stat.op_ins      = op_ins;
  assign stat.empty       = !vld_q;
  assign stat.match       = vld_q && (rd_slot.hash == op_hash) &&
                            (rd_slot.len == op_len) && key_eq;
  assign stat.last_try    = (tries == IDX_W'(CAPACITY - 1));

  always_comb begin
    case (cmd.pend_sel)
      SEL_ENTRY: pend_id_next = IDP_W'(op_id);
      SEL_SLOT:  pend_id_next = IDP_W'(rd_slot.id);
      default:   pend_id_next = miss_id;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      miss_id  <= '0;
    end else begin
      if (cmd.wr) begin
        slot_vld[idx] <= 1'b1;
      end
      if (cfg_we) begin
        miss_id <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_ins  <= kind;
      op_hash <= key_hash;
      op_len  <= key_length;
      op_key  <= key_bytes;
      op_id   <= ID_BITS'(entry_id);
      idx     <= key_hash[IDX_W-1:0];
      sq      <= IDX_W'(1);
      odd     <= IDX_W'(3);
      tries   <= '0;
    end else if (cmd.adv) begin
      idx   <= idx + sq;
      sq    <= sq + odd;
      odd   <= odd + IDX_W'(2);
      tries <= tries + IDX_W'(1);
    end
    if (cmd.rd) begin
      vld_q <= slot_vld[idx];
    end
    if (cmd.pend_load) begin
      pend_code <= cmd.pend_code;
      pend_id   <= pend_id_next;
    end
    if (cmd.out_load) begin
      status   <= pend_code;
      found_id <= pend_id;
    end
  end

endmodule

// ===== rtl/core/hashed_key_id_map_top.sv =====
// Top level of the hashed key to id map: open-addressed table with quadratic probing.
// Each transaction is a search or an insert into a 64-slot table, starting at slot
// key_hash modulo 64 and stepping by 1, 4, 9, ... slots. The table is a RAM with one
// write port and one read port and a registered read, so each probe passes through a
// read state and a compare state; a transaction takes 1 to 64 probes, and a refused
// zero-hash insert none. Slot occupancy is held in flip-flops cleared by reset, so no
// clearing pass follows reset. A finished result waits in the output register while
// the next transaction is accepted. miss_id is written through the cfg port, which is
// always ready.
module hashed_key_id_map_top import hkim_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDP_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [HASH_W-1:0] key_hash,
  input  logic [LEN_W-1:0]  key_length,
  input  logic [KEY_W-1:0]  key_bytes,
  input  logic [IDP_W-1:0]  entry_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [IDP_W-1:0]  found_id
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  hkim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hkim_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .key_hash  (key_hash),
    .key_length(key_length),
    .key_bytes (key_bytes),
    .entry_id  (entry_id),
    .status    (status),
    .found_id  (found_id)
  );

endmodule
